@@ rtl/core/krt_pkg.sv @@
// shared types and constants of the keyed record table
package krt_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ID_W      = 16;
    localparam int AGE_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int GAP_W     = 8;
    localparam int ENTRIES_W = 7;

    localparam logic [AGE_W-1:0] LOW_AGE_INIT  = 7'd30;
    localparam logic [AGE_W-1:0] HIGH_AGE_INIT = 7'd18;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_FIND_ID  = 2'd2,
        CMD_FIND_AGE = 2'd3
    } krt_cmd_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic ins;
        logic scan;
        logic shift_rd;
        logic shift_wr;
        logic fin;
    } krt_ctl_t;

    // datapath to controller
    typedef struct packed {
        krt_cmd_t cmd;
        logic     out_free;
        logic     id_hit;
        logic     scan_done;
        logic     shift_more;
    } krt_sts_t;

endpackage

@@ rtl/core/krt_req_if.sv @@
// request channel: one command beat
interface krt_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     cmd;
    logic [krt_pkg::ID_W-1:0]       rec_id;
    logic [krt_pkg::AGE_W-1:0]      rec_age;

    modport source (output valid, cmd, rec_id, rec_age, input ready);
    modport sink   (input valid, cmd, rec_id, rec_age, output ready);
endinterface

@@ rtl/core/krt_rsp_if.sv @@
// response channel: one result beat
interface krt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [krt_pkg::STATUS_W-1:0]      status;
    logic [krt_pkg::ID_W-1:0]          match_id;
    logic [krt_pkg::AGE_W-1:0]         match_age;
    logic signed [krt_pkg::GAP_W-1:0]  age_gap;
    logic [krt_pkg::ENTRIES_W-1:0]     entries;
    logic                              last;

    modport source (output valid, status, match_id, match_age, age_gap, entries, last,
                    input ready);
    modport sink   (input valid, status, match_id, match_age, age_gap, entries, last,
                    output ready);
endinterface

@@ rtl/core/keyed_record_table.sv @@
// keyed record table top level: controller, datapath and record ram
// searches and delete scan one slot a cycle, an age search pausing while an older match
//   waits for room in the result register; a delete hit then shifts every later record down
//   one slot, a read and a write each; throughput: one command at a time, req.ready is
//   registered and rises in the cycle after the final beat is pushed; reset: fill count 0,
//   bounds min 30 max 18, ram not cleared
module keyed_record_table #(
    parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    krt_req_if.sink         req,
    krt_rsp_if.source       rsp
);

    krt_pkg::krt_ctl_t ctl;
    krt_pkg::krt_sts_t sts;
    logic              req_ready;

    // fsm sequences insert, scan, shift and final-beat phases
    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    assign req.ready = req_ready;

    // datapath owns the ram, the bounds and the result register that decouples rsp
    krt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .req_cmd     (req.cmd),
        .req_id      (req.rec_id),
        .req_age     (req.rec_age),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_status  (rsp.status),
        .rsp_id      (rsp.match_id),
        .rsp_age     (rsp.match_age),
        .rsp_gap     (rsp.age_gap),
        .rsp_entries (rsp.entries),
        .rsp_last    (rsp.last)
    );

endmodule

@@ rtl/core/krt_ram.sv @@
// generic single-write, single-read ram with registered read
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/krt_ctrl.sv @@
// sequencer for insert, scan and shift phases
module krt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  krt_pkg::krt_sts_t sts,
    output krt_pkg::krt_ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_SH_RD,
        S_SH_WR,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   accept;
    logic   dispatch_pending_reg;

    assign req_ready = in_ready_reg;
    assign accept    = req_valid && in_ready_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_INS:
            begin
                ctl.ins    = 1'b1;
                state_next = S_FIN;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.cmd != krt_pkg::CMD_FIND_AGE && sts.id_hit)
                begin
                    state_next = (sts.cmd == krt_pkg::CMD_DELETE) ? S_SH_RD : S_FIN;
                end
                else if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_SH_RD:
            begin
                ctl.shift_rd = 1'b1;
                state_next   = sts.shift_more ? S_SH_WR : S_FIN;
            end
            S_SH_WR:
            begin
                ctl.shift_wr = 1'b1;
                state_next   = S_SH_RD;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command is latched at load, so an insert is redirected on the registered copy
    // in the cycle after load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            in_ready_reg         <= 1'b0;
            dispatch_pending_reg <= 1'b0;
        end
        else
        begin
            if (dispatch_pending_reg && sts.cmd == krt_pkg::CMD_INSERT)
            begin
                state_reg    <= S_INS;
                in_ready_reg <= 1'b0;
            end
            else
            begin
                state_reg    <= state_next;
                in_ready_reg <= (state_next == S_IDLE);
            end
            dispatch_pending_reg <= (state_reg == S_IDLE) && accept;
        end
    end

endmodule

@@ rtl/core/krt_datapath.sv @@
// record store, scan pointer, running bounds and result register
module krt_datapath #(
    parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  krt_pkg::krt_ctl_t                    ctl,
    output krt_pkg::krt_sts_t                    sts,
    input  logic [1:0]                           req_cmd,
    input  logic [krt_pkg::ID_W-1:0]             req_id,
    input  logic [krt_pkg::AGE_W-1:0]            req_age,
    input  logic                                 rsp_ready,
    output logic                                 rsp_valid,
    output logic [krt_pkg::STATUS_W-1:0]         rsp_status,
    output logic [krt_pkg::ID_W-1:0]             rsp_id,
    output logic [krt_pkg::AGE_W-1:0]            rsp_age,
    output logic signed [krt_pkg::GAP_W-1:0]     rsp_gap,
    output logic [krt_pkg::ENTRIES_W-1:0]        rsp_entries,
    output logic                                 rsp_last
);

    localparam int ID_W   = krt_pkg::ID_W;
    localparam int AGE_W  = krt_pkg::AGE_W;
    localparam int MEM_W  = ID_W + AGE_W;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    // ram port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [MEM_W-1:0]  mem_rdata;

    krt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    krt_pkg::krt_cmd_t             cmd_reg,        cmd_next;
    logic [ID_W-1:0]               key_id_reg,     key_id_next;
    logic [AGE_W-1:0]              key_age_reg,    key_age_next;
    logic [CNT_W-1:0]              fill_reg,       fill_next;
    logic [AGE_W-1:0]              low_reg,        low_next;
    logic [AGE_W-1:0]              high_reg,       high_next;
    logic [CNT_W-1:0]              ptr_reg,        ptr_next;
    logic                          cmp_valid_reg,  cmp_valid_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]               pend_id_reg,    pend_id_next;
    logic [AGE_W-1:0]              pend_age_reg,   pend_age_next;
    logic [krt_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ID_W-1:0]               res_id_reg,     res_id_next;
    logic [AGE_W-1:0]              res_age_reg,    res_age_next;
    logic                          out_valid_reg,  out_valid_next;
    logic [krt_pkg::STATUS_W-1:0]  out_status_reg;
    logic [ID_W-1:0]               out_id_reg;
    logic [AGE_W-1:0]              out_age_reg;
    logic signed [krt_pkg::GAP_W-1:0] out_gap_reg;
    logic [CNT_W-1:0]              out_fill_reg;
    logic                          out_last_reg;

    logic                          push;
    logic [krt_pkg::STATUS_W-1:0]  push_status;
    logic [ID_W-1:0]               push_id;
    logic [AGE_W-1:0]              push_age;
    logic                          push_last;

    logic [ID_W-1:0]  rd_id;
    logic [AGE_W-1:0] rd_age;
    logic             out_free;
    logic             issue_avail;
    logic             id_hit;
    logic             age_hit;
    logic             is_age;
    logic             stall;
    logic             scan_done;
    logic             shift_more;
    logic [CNT_W:0]   ptr_inc;
    logic signed [krt_pkg::GAP_W-1:0] gap;

    assign rd_id       = mem_rdata[MEM_W-1:AGE_W];
    assign rd_age      = mem_rdata[AGE_W-1:0];
    assign out_free    = !out_valid_reg || rsp_ready;
    assign issue_avail = ptr_reg < fill_reg;
    assign id_hit      = cmp_valid_reg && (rd_id == key_id_reg);
    assign age_hit     = cmp_valid_reg && (rd_age == key_age_reg);
    assign is_age      = (cmd_reg == krt_pkg::CMD_FIND_AGE);
    // an older match can leave only when the result register has room
    assign stall       = is_age && age_hit && pend_valid_reg && !out_free;
    assign scan_done   = !cmp_valid_reg && !issue_avail;
    assign ptr_inc     = {1'b0, ptr_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign shift_more  = ptr_inc < {1'b0, fill_reg};
    assign gap         = $signed({1'b0, high_reg}) - $signed({1'b0, low_reg});

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.out_free   = out_free;
        sts.id_hit     = id_hit;
        sts.scan_done  = scan_done;
        sts.shift_more = shift_more;
    end

    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        cmd_next        = cmd_reg;
        key_id_next     = key_id_reg;
        key_age_next    = key_age_reg;
        fill_next       = fill_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        ptr_next        = ptr_reg;
        cmp_valid_next  = cmp_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_age_next   = pend_age_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_age_next    = res_age_reg;
        push            = 1'b0;
        push_status     = res_status_reg;
        push_id         = res_id_reg;
        push_age        = res_age_reg;
        push_last       = 1'b1;

        if (ctl.load)
        begin
            cmd_next        = krt_pkg::krt_cmd_t'(req_cmd);
            key_id_next     = req_id;
            key_age_next    = req_age;
            ptr_next        = '0;
            cmp_valid_next  = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (ctl.ins)
        begin
            res_id_next  = '0;
            res_age_next = '0;
            if (fill_reg == FULL_CNT)
            begin
                res_status_next = krt_pkg::ST_FULL;
            end
            else
            begin
                mem_we          = 1'b1;
                mem_waddr       = fill_reg[ADDR_W-1:0];
                mem_wdata       = {key_id_reg, key_age_reg};
                fill_next       = fill_reg + CNT_W'(1);
                res_status_next = krt_pkg::ST_OK;
                if (key_age_reg > high_reg)
                begin
                    high_next = key_age_reg;
                end
                if (key_age_reg < low_reg)
                begin
                    low_next = key_age_reg;
                end
            end
        end

        // read one slot per cycle unless an age match stalls the scan, compare the slot read last
        if (ctl.scan && !stall)
        begin
            mem_re         = issue_avail;
            mem_raddr      = ptr_reg[ADDR_W-1:0];
            cmp_valid_next = issue_avail;
            if (issue_avail)
            begin
                ptr_next = ptr_inc[CNT_W-1:0];
            end
            if (is_age)
            begin
                if (age_hit)
                begin
                    if (pend_valid_reg)
                    begin
                        push        = 1'b1;
                        push_status = krt_pkg::ST_OK;
                        push_id     = pend_id_reg;
                        push_age    = pend_age_reg;
                        push_last   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = rd_id;
                    pend_age_next   = rd_age;
                end
            end
            else if (id_hit)
            begin
                res_status_next = krt_pkg::ST_OK;
                res_id_next     = rd_id;
                res_age_next    = rd_age;
                // back to the slot that matched, where the shift starts
                ptr_next        = ptr_reg - CNT_W'(1);
            end
            if (scan_done)
            begin
                if (is_age && pend_valid_reg)
                begin
                    res_status_next = krt_pkg::ST_OK;
                    res_id_next     = pend_id_reg;
                    res_age_next    = pend_age_reg;
                end
                else
                begin
                    res_status_next = krt_pkg::ST_MISS;
                    res_id_next     = '0;
                    res_age_next    = '0;
                end
            end
        end

        if (ctl.shift_rd)
        begin
            if (shift_more)
            begin
                mem_re    = 1'b1;
                mem_raddr = ptr_inc[ADDR_W-1:0];
            end
            else
            begin
                fill_next = fill_reg - CNT_W'(1);
            end
        end

        if (ctl.shift_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            ptr_next  = ptr_inc[CNT_W-1:0];
        end

        if (ctl.fin)
        begin
            push = 1'b1;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            low_reg        <= krt_pkg::LOW_AGE_INIT;
            high_reg       <= krt_pkg::HIGH_AGE_INIT;
            cmp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= krt_pkg::CMD_INSERT;
        end
        else
        begin
            fill_reg       <= fill_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            cmp_valid_reg  <= cmp_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_id_reg     <= key_id_next;
        key_age_reg    <= key_age_next;
        ptr_reg        <= ptr_next;
        pend_id_reg    <= pend_id_next;
        pend_age_reg   <= pend_age_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_age_reg    <= res_age_next;
        if (push)
        begin
            out_status_reg <= push_status;
            out_id_reg     <= push_id;
            out_age_reg    <= push_age;
            out_gap_reg    <= gap;
            out_fill_reg   <= fill_reg;
            out_last_reg   <= push_last;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_id      = out_id_reg;
    assign rsp_age     = out_age_reg;
    assign rsp_gap     = out_gap_reg;
    assign rsp_entries = krt_pkg::ENTRIES_W'(out_fill_reg);
    assign rsp_last    = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond table size");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result beat pushed over an untaken beat");

    a_pend_age_only: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (cmd_reg == krt_pkg::CMD_FIND_AGE))
        else $error("held age match outside an age search");

    a_fill_moves_one: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            ((fill_reg == $past(fill_reg) + CNT_W'(1)) ||
             (fill_reg == $past(fill_reg) - CNT_W'(1))))
        else $error("fill count moved by more than one");

endmodule
